[hdl/mcs_pkg.sv]
// Shared types and constants for the masked cosine similarity block.
// No dependencies; mcs_ctrl, the top level and the testbench import this package.
package mcs_pkg;

  localparam logic [47:0] SQ_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] CROSS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] CROSS_MIN = 48'h8000_0000_0000;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic [3:0]  TOP_BIT   = 4'd14;

  // element products, in order of issue
  localparam logic [1:0] PART_AA = 2'd0;
  localparam logic [1:0] PART_BB = 2'd1;
  localparam logic [1:0] PART_AB = 2'd2;

  // index of the last partial product of a wide product and of a quotient product
  localparam logic [1:0] LAST_WIDE_PART = 2'd3;
  localparam logic [1:0] LAST_PROD_PART = 2'd2;

  // limb offset of a partial product in the accumulator
  localparam logic [1:0] LIMB_0 = 2'd0;
  localparam logic [1:0] LIMB_1 = 2'd1;
  localparam logic [1:0] LIMB_2 = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_CHECK,
    ST_WIDE_MUL,
    ST_WIDE_ADD,
    ST_WIDE_STORE,
    ST_TSQ_MUL,
    ST_TSQ_ADD,
    ST_PROD_MUL,
    ST_PROD_ADD,
    ST_COMPARE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MS_ELEM,
    MS_WIDE,
    MS_TSQ,
    MS_PROD
  } mul_sel_t;

  typedef struct packed {
    logic       in_ready;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic [1:0] part;
    logic       pass;
    logic [3:0] bit_idx;
    logic       elem_add;
    logic       acc_add;
    logic [1:0] shift;
    logic       acc_clr;
    logic       den_load;
    logic       num_load;
    logic       sq_load;
    logic       q_clr;
    logic       cmp_en;
    logic       out_load;
    logic       state_clr;
  } ctl_t;

  typedef struct packed {
    logic fire;
    logic skip;
    logic last;
    logic early;
    logic out_free;
  } sts_t;

endpackage

[hdl/mcs_if.sv]
// Valid/ready channels for element pair beats and result beats.
// No dependencies.
interface mcs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_value;
  logic signed [15:0] b_value;
  logic               a_invalid;
  logic               b_invalid;
  logic               same_vector;
  logic               last;

  modport source (output valid, a_value, b_value, a_invalid, b_invalid, same_vector, last,
                  input ready);
  modport sink (input valid, a_value, b_value, a_invalid, b_invalid, same_vector, last,
                output ready);
endinterface

interface mcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] similarity;
  logic               undefined;

  modport source (output valid, similarity, undefined, input ready);
  modport sink (input valid, similarity, undefined, output ready);
endinterface

[hdl/mcs_mul.sv]
// Shared 33x33 signed multiplier with registered product.
// No dependencies.
module mcs_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] x,
  input  logic signed [32:0] y,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= x * y;
    end
  end

endmodule

[hdl/mcs_ctrl.sv]
// Sequencer: element accumulation, wide products and bitwise quotient search.
// Depends on mcs_pkg.
module mcs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  mcs_pkg::sts_t sts,
  output mcs_pkg::ctl_t ctl
);
  import mcs_pkg::*;

  state_t     state, state_next;
  logic [1:0] part, part_next;
  logic       pass, pass_next;
  logic [3:0] bit_idx, bit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      part    <= '0;
      pass    <= 1'b0;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      part    <= part_next;
      pass    <= pass_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    part_next    = part;
    pass_next    = pass;
    bit_idx_next = bit_idx;
    case (state)
      ST_IDLE: begin
        if (sts.fire) begin
          part_next  = PART_AA;
          state_next = sts.skip ? ST_CHECK : ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: state_next = ST_SQ_ADD;
      ST_SQ_ADD: begin
        if (part == PART_AB) begin
          state_next = ST_CHECK;
        end else begin
          part_next  = part + 2'd1;
          state_next = ST_SQ_MUL;
        end
      end
      ST_CHECK: begin
        if (!sts.last) begin
          state_next = ST_IDLE;
        end else if (sts.early) begin
          state_next = ST_DONE;
        end else begin
          part_next  = '0;
          pass_next  = 1'b0;
          state_next = ST_WIDE_MUL;
        end
      end
      ST_WIDE_MUL: state_next = ST_WIDE_ADD;
      ST_WIDE_ADD: begin
        if (part == LAST_WIDE_PART) begin
          state_next = ST_WIDE_STORE;
        end else begin
          part_next  = part + 2'd1;
          state_next = ST_WIDE_MUL;
        end
      end
      ST_WIDE_STORE: begin
        part_next = '0;
        if (!pass) begin
          pass_next  = 1'b1;
          state_next = ST_WIDE_MUL;
        end else begin
          bit_idx_next = TOP_BIT;
          state_next   = ST_TSQ_MUL;
        end
      end
      ST_TSQ_MUL: state_next = ST_TSQ_ADD;
      ST_TSQ_ADD: begin
        part_next  = '0;
        state_next = ST_PROD_MUL;
      end
      ST_PROD_MUL: state_next = ST_PROD_ADD;
      ST_PROD_ADD: begin
        if (part == LAST_PROD_PART) begin
          state_next = ST_COMPARE;
        end else begin
          part_next  = part + 2'd1;
          state_next = ST_PROD_MUL;
        end
      end
      ST_COMPARE: begin
        if (bit_idx == '0) begin
          state_next = ST_DONE;
        end else begin
          bit_idx_next = bit_idx - 4'd1;
          state_next   = ST_TSQ_MUL;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.mul_sel = MS_ELEM;
    ctl.part    = part;
    ctl.pass    = pass;
    ctl.bit_idx = bit_idx;
    case (state)
      ST_IDLE:     ctl.in_ready = 1'b1;
      ST_SQ_MUL:   ctl.mul_en = 1'b1;
      ST_SQ_ADD:   ctl.elem_add = 1'b1;
      ST_CHECK: begin
        ctl.acc_clr = 1'b1;
        ctl.q_clr   = 1'b1;
      end
      ST_WIDE_MUL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_WIDE;
      end
      ST_WIDE_ADD: begin
        ctl.acc_add = 1'b1;
        ctl.shift   = {1'b0, part[1]} + {1'b0, part[0]};
      end
      ST_WIDE_STORE: begin
        ctl.den_load = !pass;
        ctl.num_load = pass;
        ctl.acc_clr  = 1'b1;
      end
      ST_TSQ_MUL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_TSQ;
      end
      ST_TSQ_ADD: begin
        ctl.sq_load = 1'b1;
        ctl.acc_clr = 1'b1;
      end
      ST_PROD_MUL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_PROD;
      end
      ST_PROD_ADD: begin
        ctl.acc_add = 1'b1;
        ctl.shift   = part;
      end
      ST_COMPARE:  ctl.cmp_en = 1'b1;
      ST_DONE: begin
        ctl.out_load  = sts.out_free;
        ctl.state_clr = sts.out_free;
      end
      default: ctl.in_ready = 1'b0;
    endcase
  end

endmodule

[hdl/masked_cosine_similarity_top.sv]
// Pairs are taken one at a time: a new pair is accepted only after the sequencer is back in
// idle. A last pair's result waits for the wide products and the quotient search unless the
// result is forced or undefined, and then for any wait on the output; the shared 33x33
// multiplier, with an add after each product, serves every product: 2x4 partials for the
// wide products, then 15 quotient bits of 4 products each.
// Synchronous reset clears the sums, the sequencer and the result valid flag.
module masked_cosine_similarity_top (
  input logic        clk,
  input logic        rst,
  mcs_in_if.sink     in_ch,
  mcs_out_if.source  out_ch
);
  import mcs_pkg::*;

  ctl_t ctl;
  sts_t sts;

  logic               fire;
  logic signed [15:0] a_val, b_val;
  logic               last_r;
  logic [47:0]        saa, sbb;
  logic signed [47:0] sab;
  logic               same_seen;
  logic [47:0]        mag, src_x, src_y;
  logic signed [32:0] mx, my;
  logic signed [65:0] prod;
  logic [127:0]       acc, acc_term, num;
  logic [95:0]        den;
  logic [28:0]        sq;
  logic [14:0]        q, trial;
  logic [15:0]        q_ext;
  logic               le, early;
  logic [48:0]        saa_sum, sbb_sum;
  logic signed [48:0] sab_sum;
  logic signed [15:0] sim_val, sim_r;
  logic               undef_val, undef_r, out_valid;

  mcs_ctrl u_ctrl (.clk(clk), .rst(rst), .sts(sts), .ctl(ctl));
  mcs_mul  u_mul  (.clk(clk), .en(ctl.mul_en), .x(mx), .y(my), .p(prod));

  assign fire         = in_ch.valid && ctl.in_ready;
  assign in_ch.ready  = ctl.in_ready;
  assign early        = same_seen || (saa == '0) || (sbb == '0);
  assign sts.fire     = fire;
  assign sts.skip     = in_ch.a_invalid || in_ch.b_invalid;
  assign sts.last     = last_r;
  assign sts.early    = early;
  assign sts.out_free = !out_valid || out_ch.ready;

  assign mag   = sab[47] ? 48'(-sab) : sab;
  assign src_x = ctl.pass ? mag : saa;
  assign src_y = ctl.pass ? mag : sbb;
  assign trial = q | (15'd1 << ctl.bit_idx);
  // trials above 1.0 are rejected
  assign le    = (acc <= num) && !(trial[14] && (trial[13:0] != '0));

  assign saa_sum = {1'b0, saa} + {17'b0, prod[31:0]};
  assign sbb_sum = {1'b0, sbb} + {17'b0, prod[31:0]};
  assign sab_sum = {sab[47], sab} + prod[48:0];

  always_comb begin
    mx = '0;
    my = '0;
    case (ctl.mul_sel)
      MS_ELEM: begin
        case (ctl.part)
          PART_AA: begin
            mx = 33'(a_val);
            my = 33'(a_val);
          end
          PART_BB: begin
            mx = 33'(b_val);
            my = 33'(b_val);
          end
          default: begin
            mx = 33'(a_val);
            my = 33'(b_val);
          end
        endcase
      end
      MS_WIDE: begin
        mx = ctl.part[1] ? {17'b0, src_x[47:32]} : {1'b0, src_x[31:0]};
        my = ctl.part[0] ? {17'b0, src_y[47:32]} : {1'b0, src_y[31:0]};
      end
      MS_TSQ: begin
        mx = {18'b0, trial};
        my = {18'b0, trial};
      end
      MS_PROD: begin
        mx = {4'b0, sq};
        case (ctl.part)
          LIMB_0:  my = {1'b0, den[31:0]};
          LIMB_1:  my = {1'b0, den[63:32]};
          default: my = {1'b0, den[95:64]};
        endcase
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  always_comb begin
    case (ctl.shift)
      LIMB_0:  acc_term = {64'b0, prod[63:0]};
      LIMB_1:  acc_term = {32'b0, prod[63:0], 32'b0};
      LIMB_2:  acc_term = {prod[63:0], 64'b0};
      default: acc_term = {prod[63:0], 64'b0};
    endcase
  end

  assign q_ext = {1'b0, q};

  always_comb begin
    if (same_seen) begin
      sim_val   = ONE_Q14;
      undef_val = 1'b0;
    end else if ((saa == '0) || (sbb == '0)) begin
      sim_val   = '0;
      undef_val = 1'b1;
    end else begin
      sim_val   = sab[47] ? 16'(-q_ext) : q_ext;
      undef_val = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saa       <= '0;
      sbb       <= '0;
      sab       <= '0;
      same_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire && in_ch.same_vector) begin
        same_seen <= 1'b1;
      end
      if (ctl.elem_add) begin
        case (ctl.part)
          PART_AA: saa <= saa_sum[48] ? SQ_MAX : saa_sum[47:0];
          PART_BB: sbb <= sbb_sum[48] ? SQ_MAX : sbb_sum[47:0];
          default: begin
            if (sab_sum[48] != sab_sum[47]) begin
              sab <= sab_sum[48] ? CROSS_MIN : CROSS_MAX;
            end else begin
              sab <= sab_sum[47:0];
            end
          end
        endcase
      end
      if (ctl.state_clr) begin
        saa       <= '0;
        sbb       <= '0;
        sab       <= '0;
        same_seen <= 1'b0;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      a_val  <= in_ch.a_value;
      b_val  <= in_ch.b_value;
      last_r <= in_ch.last;
    end
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_add) begin
      acc <= acc + acc_term;
    end
    if (ctl.den_load) begin
      den <= acc[95:0];
    end
    if (ctl.num_load) begin
      num <= {acc[99:0], 28'b0};
    end
    if (ctl.sq_load) begin
      sq <= prod[28:0];
    end
    if (ctl.q_clr) begin
      q <= '0;
    end else if (ctl.cmp_en && le) begin
      q <= trial;
    end
    if (ctl.out_load) begin
      sim_r   <= sim_val;
      undef_r <= undef_val;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.similarity = sim_r;
  assign out_ch.undefined  = undef_r;

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.undefined |-> out_ch.similarity == 16'sd0)
    else $error("undefined result with nonzero similarity");

  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.similarity <= 16'sd16384) && (out_ch.similarity >= -16'sd16384))
    else $error("similarity beyond one");

  a_saa_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(ctl.state_clr) |-> saa >= $past(saa))
    else $error("sum of a squared decreased");

  a_sbb_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(ctl.state_clr) |-> sbb >= $past(sbb))
    else $error("sum of b squared decreased");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !out_valid || out_ch.ready)
    else $error("result overwritten before taken");

endmodule

[sim/tb_masked_cosine_similarity_top.sv]
// Self-checking testbench for masked_cosine_similarity_top: streams element pair beats,
// predicts each similarity result and compares it with every result beat.
// Depends on hdl/mcs_pkg.sv, hdl/mcs_if.sv and the RTL top level.
module tb_masked_cosine_similarity_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcs_pkg::*;

  typedef struct {
    logic signed [15:0] a_value;
    logic signed [15:0] b_value;
    logic               a_invalid;
    logic               b_invalid;
    logic               same_vector;
    logic               last;
  } pair_t;

  typedef struct {
    logic signed [15:0] similarity;
    logic               undefined;
  } sim_t;

  localparam int HALF_PERIOD     = 6;
  localparam int DRAIN_CYCLES    = 200;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int MAX_PRINTS      = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcs_in_if  in_ch ();
  mcs_out_if out_ch ();

  masked_cosine_similarity_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  logic [47:0]        sum_aa;
  logic [47:0]        sum_bb;
  logic signed [47:0] sum_ab;
  logic               same_seen;
  sim_t               expected_sims[$];

  int errors       = 0;
  int pairs_sent   = 0;
  int results_seen = 0;
  bit sender_gaps     = 1'b1;
  bit receiver_stalls = 1'b1;
  int hold_request    = 0;

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // largest q in [0, 1.0] with q^2 * aa * bb <= ab^2 * 2^28
  function automatic int unsigned cosine_q14(logic [47:0] aa, logic [47:0] bb,
                                             logic [47:0] mag);
    logic [127:0] den;
    logic [127:0] lim;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    den = 128'(aa) * 128'(bb);
    lim = (128'(mag) * 128'(mag)) << 28;
    lo = 0;
    hi = int'(ONE_Q14);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (den * 128'(mid * mid) <= lim) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void accumulate_pair(pair_t p);
    longint      av;
    longint      bv;
    longint      acc;
    sim_t        r;
    logic        neg;
    logic [47:0] mag;
    int unsigned q;
    av = p.a_value;
    bv = p.b_value;
    if (p.same_vector) same_seen = 1'b1;
    if (!(p.a_invalid || p.b_invalid)) begin
      acc = longint'(sum_aa) + av * av;
      sum_aa = (acc > longint'(SQ_MAX)) ? SQ_MAX : acc[47:0];
      acc = longint'(sum_bb) + bv * bv;
      sum_bb = (acc > longint'(SQ_MAX)) ? SQ_MAX : acc[47:0];
      acc = longint'(sum_ab) + av * bv;
      if (acc > longint'(CROSS_MAX)) acc = longint'(CROSS_MAX);
      if (acc < longint'($signed(CROSS_MIN))) acc = longint'($signed(CROSS_MIN));
      sum_ab = acc[47:0];
    end
    if (p.last) begin
      r.similarity = '0;
      r.undefined  = 1'b0;
      if (same_seen) begin
        r.similarity = ONE_Q14;
      end else if (sum_aa == 0 || sum_bb == 0) begin
        r.undefined = 1'b1;
      end else begin
        neg = sum_ab < 0;
        mag = neg ? -sum_ab : sum_ab;
        q = cosine_q14(sum_aa, sum_bb, mag);
        r.similarity = neg ? -16'(q) : 16'(q);
      end
      expected_sims.push_back(r);
      sum_aa = '0;
      sum_bb = '0;
      sum_ab = '0;
      same_seen = 1'b0;
    end
  endfunction

  function automatic pair_t make_pair(logic signed [15:0] a, logic signed [15:0] b,
                                      bit a_inv, bit b_inv, bit same, bit is_last);
    pair_t p;
    p.a_value     = a;
    p.b_value     = b;
    p.a_invalid   = a_inv;
    p.b_invalid   = b_inv;
    p.same_vector = same;
    p.last        = is_last;
    return p;
  endfunction

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair(bit is_last);
    pair_t p;
    int    pick;
    p.a_value = rand_value();
    pick = $urandom_range(0, 5);
    if (pick == 0) p.b_value = p.a_value;
    else if (pick == 1) p.b_value = -p.a_value;
    else p.b_value = rand_value();
    p.a_invalid   = $urandom_range(0, 9) == 0;
    p.b_invalid   = $urandom_range(0, 9) == 0;
    p.same_vector = $urandom_range(0, 24) == 0;
    p.last        = is_last;
    return p;
  endfunction

  // called at a rising edge; returns at the accepting edge, or after a sender gap
  task automatic send_pair(pair_t p);
    in_ch.valid       <= 1'b1;
    in_ch.a_value     <= p.a_value;
    in_ch.b_value     <= p.b_value;
    in_ch.a_invalid   <= p.a_invalid;
    in_ch.b_invalid   <= p.b_invalid;
    in_ch.same_vector <= p.same_vector;
    in_ch.last        <= p.last;
    do @(posedge clk); while (!in_ch.ready);
    accumulate_pair(p);
    pairs_sent++;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_random_vector(int len);
    for (int i = 0; i < len; i++) send_pair(rand_pair(i == len - 1));
  endtask

  task automatic wait_for_results();
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (expected_sims.size() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    pair_t dirs[$];
    dirs.push_back(make_pair(16'sh7fff, 16'sh8000, 0, 0, 0, 0));
    dirs.push_back(make_pair(16'sh8000, 16'sh7fff, 0, 0, 0, 1));
    dirs.push_back(make_pair(0, 0, 0, 0, 0, 1));
    dirs.push_back(make_pair(100, 0, 0, 0, 0, 1));
    dirs.push_back(make_pair(5, 5, 1, 0, 0, 0));
    dirs.push_back(make_pair(7, 7, 0, 1, 0, 0));
    dirs.push_back(make_pair(-1, -1, 1, 1, 0, 1));
    dirs.push_back(make_pair(1, 2, 0, 0, 1, 0));
    dirs.push_back(make_pair(3, -4, 0, 0, 0, 1));
    dirs.push_back(make_pair(0, 0, 0, 0, 1, 1));
    dirs.push_back(make_pair(0, 0, 1, 0, 1, 0));
    dirs.push_back(make_pair(256, 0, 0, 0, 0, 1));
    dirs.push_back(make_pair(256, 0, 0, 0, 0, 0));
    dirs.push_back(make_pair(0, 256, 0, 0, 0, 1));
    dirs.push_back(make_pair(300, 300, 0, 0, 0, 0));
    dirs.push_back(make_pair(-1000, -1000, 0, 0, 0, 1));
    dirs.push_back(make_pair(1, -1, 0, 0, 0, 1));
    dirs.push_back(make_pair(100, 200, 0, 0, 0, 0));
    dirs.push_back(make_pair(9, 9, 1, 0, 0, 1));
    dirs.push_back(make_pair(-1, 1, 0, 0, 0, 0));
    dirs.push_back(make_pair(16'sh7fff, 16'sh7fff, 0, 0, 0, 0));
    dirs.push_back(make_pair(16'sh8000, 0, 0, 0, 0, 1));
    foreach (dirs[i]) send_pair(dirs[i]);
    wait_for_results();
  endtask

  task automatic test_random_vectors(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      send_random_vector(len);
      sent += len;
    end
  endtask

  // result beats are held off while vectors keep coming, so the input backs up
  task automatic test_output_hold_off();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (6) send_random_vector(3);
    wait_for_results();
  endtask

  task automatic test_drain_pause();
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    repeat (2) send_random_vector($urandom_range(1, 4));
    wait_for_results();
    repeat (2) send_random_vector($urandom_range(1, 4));
  endtask

  always @(posedge clk) begin : check_results
    sim_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_sims.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: similarity=%0d undefined=%0b",
                                  out_ch.similarity, out_ch.undefined));
      end else begin
        e = expected_sims.pop_front();
        if (out_ch.similarity !== e.similarity)
          report_mismatch($sformatf("similarity %0d, expected %0d",
                                    out_ch.similarity, e.similarity));
        if (out_ch.undefined !== e.undefined)
          report_mismatch($sformatf("undefined %0b, expected %0b",
                                    out_ch.undefined, e.undefined));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #6_000_000;
    $display("Timeout: results still outstanding: %0d", expected_sims.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.a_value     = '0;
    in_ch.b_value     = '0;
    in_ch.a_invalid   = 1'b0;
    in_ch.b_invalid   = 1'b0;
    in_ch.same_vector = 1'b0;
    in_ch.last        = 1'b0;
    sum_aa    = '0;
    sum_bb    = '0;
    sum_ab    = '0;
    same_seen = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_vectors(250);
    test_output_hold_off();
    test_drain_pause();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    test_random_vectors(150);
    wait_for_results();

    foreach (expected_sims[i])
      report_mismatch($sformatf("missing result: similarity=%0d undefined=%0b",
                                expected_sims[i].similarity, expected_sims[i].undefined));
    $display("Covered %0d pair beats and %0d result beats: extremes, masked pairs,",
             pairs_sent, results_seen);
    $display("same-vector and zero-denominator cases, random stalls and a %0d-cycle hold-off.",
             HOLD_OFF_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mcs_pkg.sv
hdl/mcs_if.sv
hdl/mcs_mul.sv
hdl/mcs_ctrl.sv
hdl/masked_cosine_similarity_top.sv
sim/tb_masked_cosine_similarity_top.sv
